@@ rtl/rhte_pkg.sv @@
`timescale 1ns / 1ps

package rhte_pkg;

   localparam int KEY_W      = 64;
   localparam int HINT_W     = 32;
   localparam int POS_W      = 32;
   localparam int PREFIX_W   = 6;
   localparam int IDX_BITS_W = 4;
   // effective table bits, 1 up to the largest supported table of MAX_INDEX_BITS bits
   localparam int EFF_W      = 5;
   localparam int SUM_W      = 7;
   localparam int CSR_DATA_W = 6;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_LEN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS = 1'b1;

   localparam logic [PREFIX_W-1:0]   PREFIX_RESET     = 6'd0;
   localparam logic [IDX_BITS_W-1:0] INDEX_BITS_RESET = 4'd12;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_FINISH = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [KEY_W-1:0]   key;
      logic [POS_W-1:0]   position;
   } req_payload_type;

   typedef struct packed {
      logic [HINT_W-1:0]  hint;
      logic               out_of_range;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WALK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic setup;
      logic walk_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   out_of_range;
      logic   radix_eq_prev;
      logic   walk_more;
      logic   out_busy;
   } status_type;

endpackage

@@ rtl/radix_hint_table_engine_top.sv @@
`timescale 1ns / 1ps

// Radix hint table for a learned index, one item at a time. A lookup passes
// capture with the radix shift, decode with the table read, and the result
// register; it waits in emit while the output register is still full. A load
// writes the gap since the previous radix plus its own entry (only its own
// entry when it comes below the previous radix), writes nothing when its
// radix repeats the previous one, and returns a result only when out of range;
// finish fills the tail past the previous radix. The hint table has a single
// write port, one entry per cycle. After reset the table is cleared by the same
// walk with req_ready low; CSR writes are taken meanwhile. A result waiting in
// the output register does not hold off the next transfer in.
module radix_hint_table_engine_top #(
   parameter int MAX_INDEX_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rhte_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rhte_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [rhte_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rhte_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [rhte_pkg::PREFIX_W-1:0]   prefix_ff;
   logic [rhte_pkg::IDX_BITS_W-1:0] index_bits_ff;
   logic [rhte_pkg::EFF_W-1:0]      index_bits_ext;
   logic [rhte_pkg::EFF_W-1:0]      eff_bits;
   rhte_pkg::cmd_type               cmd;
   rhte_pkg::status_type            sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff     <= rhte_pkg::PREFIX_RESET;
         index_bits_ff <= rhte_pkg::INDEX_BITS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rhte_pkg::CSR_PREFIX_LEN: prefix_ff <= csr_wdata[rhte_pkg::PREFIX_W-1:0];
            rhte_pkg::CSR_INDEX_BITS: index_bits_ff <= csr_wdata[rhte_pkg::IDX_BITS_W-1:0];
            default: begin
               prefix_ff <= prefix_ff;
            end
         endcase
      end
   end

   // zero acts as one, anything past the table acts as the full table
   always_comb begin
      index_bits_ext = rhte_pkg::EFF_W'(index_bits_ff);
      if (index_bits_ext == '0) begin
         eff_bits = rhte_pkg::EFF_W'(1);
      end else if (index_bits_ext > rhte_pkg::EFF_W'(MAX_INDEX_BITS)) begin
         eff_bits = rhte_pkg::EFF_W'(MAX_INDEX_BITS);
      end else begin
         eff_bits = index_bits_ext;
      end
   end

   rhte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rhte_datapath #(
      .MAX_INDEX_BITS (MAX_INDEX_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_payload   (req_payload),
      .prefix_len    (prefix_ff),
      .eff_bits      (eff_bits),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload)
   );

endmodule

@@ rtl/rhte_ctrl.sv @@
`timescale 1ns / 1ps

module rhte_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rhte_pkg::status_type sts,
   output rhte_pkg::cmd_type   cmd
);

   rhte_pkg::state_type state_ff;
   rhte_pkg::state_type state_in;

   // reset lands in the walk state: the datapath comes out of reset set up
   // to clear the whole table
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rhte_pkg::ST_WALK;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         rhte_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = rhte_pkg::ST_DECIDE;
            end
         end
         rhte_pkg::ST_DECIDE: begin
            unique case (sts.op)
               rhte_pkg::OP_LOAD: begin
                  if (sts.out_of_range) begin
                     state_in = rhte_pkg::ST_EMIT;
                  end else if (sts.radix_eq_prev) begin
                     state_in = rhte_pkg::ST_IDLE;
                  end else begin
                     cmd.setup = 1'b1;
                     state_in  = rhte_pkg::ST_WALK;
                  end
               end
               rhte_pkg::OP_FINISH: begin
                  cmd.setup = 1'b1;
                  state_in  = rhte_pkg::ST_WALK;
               end
               rhte_pkg::OP_LOOKUP: begin
                  state_in = rhte_pkg::ST_EMIT;
               end
               rhte_pkg::OP_NONE: begin
                  state_in = rhte_pkg::ST_IDLE;
               end
            endcase
         end
         rhte_pkg::ST_WALK: begin
            if (sts.walk_more) begin
               cmd.walk_step = 1'b1;
            end else begin
               state_in = rhte_pkg::ST_IDLE;
            end
         end
         rhte_pkg::ST_EMIT: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = rhte_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rhte_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_walk_blocks_input: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> !req_ready)
      else $error("table write while input is open");

   a_emit_into_free_reg: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !sts.out_busy)
      else $error("result overwrites one not yet transferred");

   a_capture_then_decide: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == rhte_pkg::ST_DECIDE))
      else $error("accepted item not decoded next cycle");

   a_walk_in_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> sts.walk_more)
      else $error("table write past the walk limit");
`endif

endmodule

@@ rtl/rhte_datapath.sv @@
`timescale 1ns / 1ps

module rhte_datapath #(
   parameter int MAX_INDEX_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rhte_pkg::cmd_type                   cmd,
   output rhte_pkg::status_type                sts,
   input  rhte_pkg::req_payload_type           req_payload,
   input  logic [rhte_pkg::PREFIX_W-1:0]       prefix_len,
   input  logic [rhte_pkg::EFF_W-1:0]          eff_bits,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rhte_pkg::rsp_payload_type           rsp_payload
);

   localparam int AW    = MAX_INDEX_BITS;
   localparam int CW    = AW + 1;
   localparam int DEPTH = 1 << AW;

   logic [rhte_pkg::HINT_W-1:0] hint_mem [DEPTH];
   logic [rhte_pkg::HINT_W-1:0] rd_data_ff;

   logic [rhte_pkg::KEY_W-1:0]  radix_ff, radix_in;
   rhte_pkg::op_type            op_ff;
   logic [rhte_pkg::POS_W-1:0]  pos_ff;
   logic [AW-1:0]               prev_ff, prev_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [CW-1:0]               limit_ff, limit_in;
   logic [rhte_pkg::HINT_W-1:0] fill_ff, fill_in;
   logic                        rsp_valid_ff;
   rhte_pkg::rsp_payload_type   rsp_payload_ff;

   logic [rhte_pkg::SUM_W-1:0]    width_sum;
   logic [rhte_pkg::PREFIX_W-1:0] shamt;
   logic [rhte_pkg::KEY_W-1:0]    cleared;
   logic                          oor;
   logic [AW-1:0]                 idx;
   logic [CW-1:0]                 size;

   // radix of the incoming key
   always_comb begin
      width_sum = rhte_pkg::SUM_W'(prefix_len) + rhte_pkg::SUM_W'(eff_bits);
      shamt     = (width_sum > rhte_pkg::SUM_W'(rhte_pkg::KEY_W)) ? '0
                : rhte_pkg::PREFIX_W'(rhte_pkg::SUM_W'(rhte_pkg::KEY_W) - width_sum);
      cleared   = req_payload.key & ({rhte_pkg::KEY_W{1'b1}} >> prefix_len);
      radix_in  = cleared >> shamt;
   end

   // out of range only when prefix plus table bits overrun the key
   assign oor  = |(radix_ff & ({rhte_pkg::KEY_W{1'b1}} << eff_bits));
   assign idx  = radix_ff[AW-1:0];
   assign size = CW'(1) << eff_bits;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         radix_ff <= radix_in;
         op_ff    <= req_payload.op;
         pos_ff   <= req_payload.position;
      end
   end

   // walk setup: a load fills the skipped gap and its own entry, an unsorted
   // load writes its own entry only, finish fills the tail with the size
   always_comb begin
      prev_in  = prev_ff;
      cnt_in   = cnt_ff;
      limit_in = limit_ff;
      fill_in  = fill_ff;
      if (cmd.setup) begin
         unique case (op_ff)
            rhte_pkg::OP_LOAD: begin
               cnt_in   = (idx > prev_ff) ? CW'(prev_ff) + CW'(1) : CW'(idx);
               limit_in = CW'(idx) + CW'(1);
               fill_in  = pos_ff;
               prev_in  = idx;
            end
            rhte_pkg::OP_FINISH: begin
               cnt_in   = CW'(prev_ff) + CW'(1);
               limit_in = size;
               fill_in  = rhte_pkg::HINT_W'(size);
               prev_in  = '0;
            end
            default: begin
               prev_in = prev_ff;
            end
         endcase
      end else if (cmd.walk_step) begin
         cnt_in = cnt_ff + CW'(1);
      end
   end

   // reset values set up the clearing walk over the whole table
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         cnt_ff   <= '0;
         limit_ff <= CW'(DEPTH);
         fill_ff  <= '0;
      end else begin
         prev_ff  <= prev_in;
         cnt_ff   <= cnt_in;
         limit_ff <= limit_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_step) begin
         hint_mem[cnt_ff[AW-1:0]] <= fill_ff;
      end
      rd_data_ff <= hint_mem[idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_payload_ff.hint         <= oor ? '0 : rd_data_ff;
         rsp_payload_ff.out_of_range <= oor;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      sts.op            = op_ff;
      sts.out_of_range  = oor;
      sts.radix_eq_prev = (idx == prev_ff);
      sts.walk_more     = (cnt_ff < limit_ff);
      sts.out_busy      = rsp_valid_ff & ~rsp_ready;
   end

endmodule
